// ----- src/sactd_pkg.sv -----
// Package for the set-associative tag directory.
// Holds geometry constants, request and result codes, and the entry type.
// No dependencies.
package sactd_pkg;

  localparam int SETS       = 64;
  localparam int WAYS       = 4;
  localparam int LINE_BYTES = 64;

  localparam int SH         = $clog2(LINE_BYTES);
  localparam int SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LINE_W     = 64 - SH;
  localparam int IDX_W      = $clog2(SETS * WAYS) > 0 ? $clog2(SETS * WAYS) : 1;
  localparam int ENTRIES    = SETS * WAYS;
  localparam int CNT_W      = 14;

  localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_MAINT = 2'd2;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_WB   = 2'd1;
  localparam logic [1:0] KIND_FILL = 2'd2;
  localparam logic [1:0] KIND_FWD  = 2'd3;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic              valid;
    logic              dirty;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] req_address;
    logic [12:0] req_bytes;
    logic        fwd_clean;
    logic        fwd_inval;
    logic        hit;
    logic        last;
  } result_t;

endpackage

// ----- src/sactd_store.sv -----
// Tag store memory: one write port and one read port, registered read data.
// Depends on sactd_pkg.
module sactd_store import sactd_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/sactd_lfsr.sv -----
// Replacement random generator with seed load and single-step advance.
// Depends on sactd_pkg.
module sactd_lfsr import sactd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [31:0] seed,
  input  logic        step,
  output logic [31:0] nxt_val,
  output logic [31:0] val
);

  logic [31:0] lfsr_r;

  assign nxt_val = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : 32'd0);
  assign val     = lfsr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= 32'd1;
    end else if (load) begin
      lfsr_r <= (seed == 32'd0) ? 32'd1 : seed;
    end else if (step) begin
      lfsr_r <= nxt_val;
    end
  end

endmodule

// ----- src/set_assoc_cache_tag_directory_top.sv -----
// Top level of the set-associative tag directory.
// Depends on sactd_pkg, sactd_store and sactd_lfsr.
//
// Usage: items enter on in_* with in_valid/in_stall; results leave on out_*
// with out_valid/out_stall. One item is handled at a time: in_stall is high
// from acceptance until the cycle after the last result item has been taken.
// After reset the block runs a clearing pass that invalidates every one of
// the SETS*WAYS (256 here) directory entries; in_stall stays high meanwhile.
// The sequencer reads one way per cycle through the store's single read port:
// the lookup reads each way of the set in turn, and the completion marks a
// write hit dirty and builds the result item. A miss steps the replacement
// generator to pick a victim way, reads it, writes the refill and emits a
// refill result item; a dirty victim holding another line first emits a
// write-back item. Maintenance looks up each line of the range, up to 65
// lines, cleans or invalidates it where found, then emits the forward item.
// Each result item is held while out_stall is high; nothing is lost.
// The seed register is written on cfg_valid and cfg_ready and loads the
// replacement generator at once; cfg_ready is always high.
module set_assoc_cache_tag_directory_top import sactd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_address,
  input  logic [12:0] in_size_bytes,
  input  logic        in_do_clean,
  input  logic        in_do_inval,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [63:0] out_req_address,
  output logic [12:0] out_req_bytes,
  output logic        out_fwd_clean,
  output logic        out_fwd_inval,
  output logic        out_hit,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_lfsr_seed
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_VRD   = 4'd4;
  localparam logic [3:0] S_VCHK  = 4'd5;
  localparam logic [3:0] S_FILL  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;
  localparam logic [3:0] S_MNXT  = 4'd8;
  localparam logic [3:0] S_FWD   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]        state_r, state_nxt, ret_r, ret_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic [1:0]        type_r, type_nxt;
  logic [63:0]       addr_r, addr_nxt;
  logic [12:0]       size_r, size_nxt;
  logic              clean_r, clean_nxt, inval_r, inval_nxt;
  logic [LINE_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WAY_W:0]    way_r, way_nxt;
  logic              found_r, found_nxt;
  logic [WAY_W-1:0]  fway_r, fway_nxt;
  entry_t            fent_r, fent_nxt;
  result_t           res_r, res_nxt;
  logic              ov_r, ov_nxt;

  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  entry_t            wdata, rdata;
  logic              lfsr_step;
  logic [31:0]       lfsr_nv, lfsr_v;

  logic [SET_W-1:0]  cur_set;
  logic [13:0]       span;
  logic [12:0]       size_sat;

  sactd_store u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  sactd_lfsr u_lfsr (
    .clk(clk), .rst_n(rst_n), .load(cfg_valid && cfg_ready), .seed(cfg_lfsr_seed),
    .step(lfsr_step), .nxt_val(lfsr_nv), .val(lfsr_v)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_kind        = res_r.kind;
  assign out_req_address = res_r.req_address;
  assign out_req_bytes   = res_r.req_bytes;
  assign out_fwd_clean   = res_r.fwd_clean;
  assign out_fwd_inval   = res_r.fwd_inval;
  assign out_hit         = res_r.hit;
  assign out_last        = res_r.last;

  assign size_sat = (in_size_bytes > 13'd4096) ? 13'd4096 : in_size_bytes;
  assign span = {1'b0, size_sat} + 14'(in_address[SH-1:0]) + 14'(LINE_BYTES - 1);
  if (SETS > 1) begin : g_set
    assign cur_set = cur_r[SET_W-1:0];
  end else begin : g_noset
    assign cur_set = '0;
  end

  function automatic logic [IDX_W-1:0] idx_of(logic [SET_W-1:0] s, logic [WAY_W-1:0] w);
    return IDX_W'(32'(s) * WAYS + 32'(w));
  endfunction

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    clr_nxt   = clr_r;
    type_nxt  = type_r;
    addr_nxt  = addr_r;
    size_nxt  = size_r;
    clean_nxt = clean_r;
    inval_nxt = inval_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    way_nxt   = way_r;
    found_nxt = found_r;
    fway_nxt  = fway_r;
    fent_nxt  = fent_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r;
    we        = 1'b0;
    waddr     = idx_of(cur_set, fway_r);
    wdata     = fent_r;
    raddr     = idx_of(cur_set, way_r[WAY_W-1:0]);
    lfsr_step = 1'b0;
    unique case (state_r)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          type_nxt  = in_req_type;
          addr_nxt  = in_address;
          size_nxt  = size_sat;
          clean_nxt = in_do_clean;
          inval_nxt = in_do_inval;
          cur_nxt   = in_address[63:SH];
          cnt_nxt   = CNT_W'(span >> SH);
          way_nxt   = '0;
          found_nxt = 1'b0;
          priority if (in_req_type == REQ_READ || in_req_type == REQ_WRITE) begin
            state_nxt = S_RD;
          end else if (in_req_type == REQ_MAINT) begin
            state_nxt = (span >> SH) == 14'd0 ? S_FWD : S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RD: begin
        way_nxt   = way_r + 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!found_r && rdata.valid && rdata.line == cur_r) begin
          found_nxt = 1'b1;
          fway_nxt  = WAY_W'(way_r - 1'b1);
          fent_nxt  = rdata;
        end
        if (way_r == (WAY_W+1)'(WAYS)) begin
          way_nxt = '0;
          if (type_r == REQ_MAINT) begin
            state_nxt = S_MNXT;
          end else begin
            state_nxt = (found_nxt) ? S_DONE : S_VRD;
          end
        end else begin
          way_nxt = way_r + 1'b1;
        end
      end
      S_VRD: begin
        lfsr_step = 1'b1;
        fway_nxt  = WAY_W'(lfsr_nv % WAYS);
        state_nxt = S_VCHK;
      end
      S_VCHK: begin
        raddr     = idx_of(cur_set, fway_r);
        state_nxt = S_FILL;
      end
      S_FILL: begin
        we          = 1'b1;
        wdata.line  = cur_r;
        wdata.valid = 1'b1;
        wdata.dirty = (type_r == REQ_WRITE);
        res_nxt.kind      = KIND_FILL;
        res_nxt.req_address = {cur_r, SH'(0)};
        res_nxt.req_bytes = 13'(LINE_BYTES);
        res_nxt.fwd_clean = 1'b0;
        res_nxt.fwd_inval = 1'b0;
        res_nxt.hit       = 1'b0;
        res_nxt.last      = 1'b0;
        if (rdata.valid && rdata.dirty && rdata.line != cur_r) begin
          res_nxt.kind        = KIND_WB;
          res_nxt.req_address = {rdata.line, SH'(0)};
          ret_nxt = S_FILL;
          fent_nxt.valid = 1'b0;
        end else begin
          ret_nxt = S_DONE;
        end
        ov_nxt    = 1'b1;
        state_nxt = S_OUT;
      end
      S_DONE: begin
        if (found_r && type_r == REQ_WRITE) begin
          we          = 1'b1;
          wdata       = fent_r;
          wdata.dirty = 1'b1;
        end
        res_nxt.kind        = KIND_DONE;
        res_nxt.req_address = addr_r;
        res_nxt.req_bytes   = '0;
        res_nxt.fwd_clean   = 1'b0;
        res_nxt.fwd_inval   = 1'b0;
        res_nxt.hit         = found_r;
        res_nxt.last        = 1'b1;
        ov_nxt    = 1'b1;
        ret_nxt   = S_IDLE;
        state_nxt = S_OUT;
      end
      S_MNXT: begin
        if (found_r) begin
          we          = 1'b1;
          wdata       = fent_r;
          wdata.dirty = fent_r.dirty && !clean_r;
          wdata.valid = fent_r.valid && !inval_r;
        end
        found_nxt = 1'b0;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1) || cur_r == '1) begin
          state_nxt = S_FWD;
        end else begin
          cur_nxt   = cur_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_FWD: begin
        res_nxt.kind        = KIND_FWD;
        res_nxt.req_address = addr_r;
        res_nxt.req_bytes   = size_r;
        res_nxt.fwd_clean   = clean_r;
        res_nxt.fwd_inval   = inval_r;
        res_nxt.hit         = 1'b0;
        res_nxt.last        = 1'b1;
        ov_nxt    = 1'b1;
        ret_nxt   = S_IDLE;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          if (ret_r == S_FILL) begin
            raddr     = idx_of(cur_set, fway_r);
            state_nxt = S_VCHK;
          end else begin
            state_nxt = ret_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r  <= type_nxt;
    addr_r  <= addr_nxt;
    size_r  <= size_nxt;
    clean_r <= clean_nxt;
    inval_r <= inval_nxt;
    cur_r   <= cur_nxt;
    cnt_r   <= cnt_nxt;
    way_r   <= way_nxt;
    found_r <= found_nxt;
    fway_r  <= fway_nxt;
    fent_r  <= fent_nxt;
    res_r   <= res_nxt;
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("result valid outside output state");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_req_address))
    else $error("stalled result changed");
  a_lfsr_nz: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_v != 32'd0) else $error("replacement generator locked at zero");

endmodule

// ----- bench/sactd_checker.sv -----
// Checker for the set-associative tag directory: predicts result items from
// accepted input items and seed writes, and compares them with the output.
// Depends on sactd_pkg.
`timescale 1ns / 1ps
module sactd_checker import sactd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_address,
  input  logic [12:0] in_size_bytes,
  input  logic        in_do_clean,
  input  logic        in_do_inval,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [63:0] out_req_address,
  input  logic [12:0] out_req_bytes,
  input  logic        out_fwd_clean,
  input  logic        out_fwd_inval,
  input  logic        out_hit,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_lfsr_seed,
  output int          fails,
  output int          pending
);

  entry_t      dir_model [ENTRIES];
  logic [31:0] lfsr_model;
  result_t     expected_results [$];

  initial fails = 0;
  assign pending = expected_results.size();

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fails++;
  endtask

  function automatic result_t mk(logic [1:0] k, logic [63:0] a, logic [12:0] b,
                                 logic c, logic i, logic h, logic l);
    result_t r;
    r.kind = k; r.req_address = a; r.req_bytes = b;
    r.fwd_clean = c; r.fwd_inval = i; r.hit = h; r.last = l;
    return r;
  endfunction

  function automatic int find_way(logic [LINE_W-1:0] ln);
    int base;
    base = int'(ln % SETS) * WAYS;
    for (int w = 0; w < WAYS; w++)
      if (dir_model[base + w].valid && dir_model[base + w].line == ln) return base + w;
    return -1;
  endfunction

  task automatic predict_item(logic [1:0] t, logic [63:0] a, logic [12:0] s,
                              logic c, logic i);
    logic [LINE_W-1:0] ln;
    logic [LINE_W-1:0] cur;
    logic [63:0]       cnt;
    logic [12:0]       sz;
    int                idx;
    ln = a[63:SH];
    sz = (s > 13'd4096) ? 13'd4096 : s;
    if (t == REQ_READ || t == REQ_WRITE) begin
      idx = find_way(ln);
      if (idx >= 0) begin
        if (t == REQ_WRITE) dir_model[idx].dirty = 1'b1;
        expected_results.push_back(mk(KIND_DONE, a, 13'd0, 0, 0, 1, 1));
      end else begin
        lfsr_model = (lfsr_model >> 1) ^ (lfsr_model[0] ? LFSR_TAPS : 32'd0);
        idx = int'(ln % SETS) * WAYS + int'(lfsr_model % WAYS);
        if (dir_model[idx].valid && dir_model[idx].dirty)
          expected_results.push_back(mk(KIND_WB, {dir_model[idx].line, {SH{1'b0}}},
                                        13'(LINE_BYTES), 0, 0, 0, 0));
        dir_model[idx].line  = ln;
        dir_model[idx].valid = 1'b1;
        dir_model[idx].dirty = (t == REQ_WRITE);
        expected_results.push_back(mk(KIND_FILL, {ln, {SH{1'b0}}}, 13'(LINE_BYTES),
                                      0, 0, 0, 0));
        expected_results.push_back(mk(KIND_DONE, a, 13'd0, 0, 0, 0, 1));
      end
    end else if (t == REQ_MAINT) begin
      cnt = (64'(a[SH-1:0]) + 64'(sz) + 64'(LINE_BYTES - 1)) >> SH;
      cur = ln;
      for (longint n = 0; n < longint'(cnt); n++) begin
        idx = find_way(cur);
        if (idx >= 0) begin
          if (c) dir_model[idx].dirty = 1'b0;
          if (i) dir_model[idx].valid = 1'b0;
        end
        if (&cur) break;
        cur++;
      end
      expected_results.push_back(mk(KIND_FWD, a, sz, c, i, 0, 1));
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t exp_r;
    if (!rst_n) begin
      for (int e = 0; e < ENTRIES; e++) dir_model[e] = '0;
      lfsr_model = 32'd1;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        lfsr_model = (cfg_lfsr_seed == 32'd0) ? 32'd1 : cfg_lfsr_seed;
      if (in_valid && !in_stall)
        predict_item(in_req_type, in_address, in_size_bytes, in_do_clean, in_do_inval);
      if (out_valid && !out_stall) begin
        got = mk(out_kind, out_req_address, out_req_bytes, out_fwd_clean,
                 out_fwd_inval, out_hit, out_last);
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result item kind %0d addr %h", got.kind,
                           got.req_address));
        end else begin
          exp_r = expected_results.pop_front();
          if (got.kind !== exp_r.kind)
            report($sformatf("kind %0d, want %0d", got.kind, exp_r.kind));
          if (got.req_address !== exp_r.req_address)
            report($sformatf("req_address %h, want %h", got.req_address,
                             exp_r.req_address));
          if (got.req_bytes !== exp_r.req_bytes)
            report($sformatf("req_bytes %0d, want %0d", got.req_bytes, exp_r.req_bytes));
          if (got.fwd_clean !== exp_r.fwd_clean)
            report($sformatf("fwd_clean %b, want %b", got.fwd_clean, exp_r.fwd_clean));
          if (got.fwd_inval !== exp_r.fwd_inval)
            report($sformatf("fwd_inval %b, want %b", got.fwd_inval, exp_r.fwd_inval));
          if (got.hit !== exp_r.hit)
            report($sformatf("hit %b, want %b", got.hit, exp_r.hit));
          if (got.last !== exp_r.last)
            report($sformatf("last %b, want %b", got.last, exp_r.last));
        end
      end
    end
  end

endmodule

// ----- bench/tb_set_assoc_cache_tag_directory_top.sv -----
// Testbench top for the set-associative tag directory: drives directed and
// random items and seed writes, and gives the verdict.
// Depends on sactd_pkg, sactd_checker and the block under test.
`timescale 1ns / 1ps
module tb_set_assoc_cache_tag_directory_top;
  import sactd_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_READ;
  logic [63:0] in_address = '0;
  logic [12:0] in_size_bytes = '0;
  logic        in_do_clean = 1'b0;
  logic        in_do_inval = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [63:0] out_req_address;
  logic [12:0] out_req_bytes;
  logic        out_fwd_clean;
  logic        out_fwd_inval;
  logic        out_hit;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_lfsr_seed = '0;
  int          fails;
  int          pending;
  logic [63:0] tag_pool [6];

  set_assoc_cache_tag_directory_top dut (.*);
  sactd_checker chk (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (gap_len() + 1) @(posedge clk);
        out_stall <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [1:0] t, logic [63:0] a, logic [12:0] s,
                           logic c, logic i);
    in_valid      <= 1'b1;
    in_req_type   <= t;
    in_address    <= a;
    in_size_bytes <= s;
    in_do_clean   <= c;
    in_do_inval   <= i;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap_len() > 0) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic write_seed(logic [31:0] seed);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_lfsr_seed <= seed;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    logic [1:0]  t;
    logic [63:0] a;
    logic [12:0] s;
    int          r;
    r = $urandom_range(0, 99);
    t = (r < 45) ? REQ_READ : (r < 85) ? REQ_WRITE : (r < 97) ? REQ_MAINT : 2'd3;
    if ($urandom_range(0, 9) == 0)
      a = {$urandom, $urandom};
    else
      a = {tag_pool[$urandom_range(0, 5)][63:12], 6'($urandom_range(0, 3)),
           6'($urandom)};
    s = ($urandom_range(0, 99) < 85) ? 13'($urandom_range(0, 200))
                                     : 13'($urandom_range(0, 8191));
    send_item(t, a, s, 1'($urandom), 1'($urandom));
  endtask

  initial begin
    logic [31:0] seeds [4];
    seeds[0] = 32'hFFFF_FFFF;
    seeds[1] = $urandom;
    seeds[2] = 32'd1;
    seeds[3] = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_seed(32'd0);

    send_item(REQ_READ, 64'd0, 13'd0, 0, 0);
    send_item(REQ_WRITE, 64'd4, 13'd8, 0, 0);
    send_item(REQ_READ, 64'd63, 13'd1, 0, 0);
    for (int k = 1; k <= 7; k++)
      send_item(REQ_WRITE, 64'(k) << 12, 13'd4, 0, 0);
    send_item(REQ_MAINT, 64'h1000, 13'd64, 1, 0);
    send_item(REQ_MAINT, 64'h2010, 13'd4096, 0, 1);
    send_item(REQ_MAINT, 64'h3000, 13'd1, 1, 1);
    send_item(REQ_MAINT, 64'h4000, 13'd0, 0, 0);
    send_item(REQ_MAINT, 64'h5555_0000_0000, 13'd300, 1, 1);
    send_item(REQ_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 13'd1, 0, 0);
    send_item(REQ_MAINT, 64'hFFFF_FFFF_FFFF_FF80, 13'd8191, 1, 0);
    send_item(REQ_READ, 64'hFFFF_FFFF_FFFF_FFC0, 13'd4096, 0, 0);
    send_item(REQ_MAINT, 64'hFFFF_FFFF_FFFF_FFC1, 13'd4097, 0, 1);
    send_item(2'd3, 64'hDEAD_BEEF, 13'd5, 1, 1);
    send_item(REQ_READ, 64'hFFFF_FFFF_FFFF_FFC0, 13'd8191, 1, 1);

    for (int ph = 0; ph < 4; ph++) begin
      write_seed(seeds[ph]);
      for (int p = 0; p < 6; p++) tag_pool[p] = {$urandom, $urandom};
      for (int n = 0; n < 125; n++) random_item();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
